### hdl/cwp_pkg.sv
// Package for the certificate text-to-word parser.
// Holds field widths, error codes, packing constants and character helpers.
// No dependencies.
`default_nettype none

package cwp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 64;
  localparam int unsigned DegW   = 6;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned DegShift = 48;

  localparam logic [DegW-1:0]  DegLimitReset = DegW'(47);
  localparam logic [WordW-1:0] AllOnes       = {WordW{1'b1}};

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [DegW-1:0]  deg_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_LINE   = 3'd1,
    ERR_LINE_MISM = 3'd2,
    ERR_NOT_U_DIG = 3'd3,
    ERR_NO_P      = 3'd4,
    ERR_BAD_HEX   = 3'd5,
    ERR_SIZE_MISM = 3'd6
  } err_t;

  localparam byte_t ChSpace = 8'h20;
  localparam byte_t ChTab   = 8'h09;
  localparam byte_t ChLf    = 8'h0A;
  localparam byte_t ChCr    = 8'h0D;
  localparam byte_t ChZero  = 8'h30;
  localparam byte_t ChNine  = 8'h39;
  localparam byte_t ChU     = 8'h75;
  localparam byte_t ChP     = 8'h70;
  localparam byte_t ChLowA  = 8'h61;
  localparam byte_t ChLowF  = 8'h66;
  localparam byte_t ChUpA   = 8'h41;
  localparam byte_t ChUpF   = 8'h46;

  // Returns {valid, value} for one hex character.
  function automatic logic [4:0] hex_digit(input byte_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= ChZero && c <= ChNine) begin
      r = {1'b1, 4'(c - ChZero)};
    end else if (c >= ChLowA && c <= ChLowF) begin
      r = {1'b1, 4'(c - ChLowA + 8'd10)};
    end else if (c >= ChUpA && c <= ChUpF) begin
      r = {1'b1, 4'(c - ChUpA + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/cwp_ifs.sv
// Channel interfaces for the certificate text-to-word parser.
// Depends on cwp_pkg for field widths.
`default_nettype none

interface cwp_in_if;
  logic              valid;
  logic              ready;
  cwp_pkg::byte_t    text_byte;
  logic              end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface cwp_out_if;
  logic                          valid;
  logic                          ready;
  cwp_pkg::word_t                packed_word;
  logic                          word_valid;
  logic                          finished;
  logic [cwp_pkg::ErrW-1:0]      error_code;

  modport source (output valid, output packed_word, output word_valid, output finished,
                  output error_code, input ready);
  modport sink   (input valid, input packed_word, input word_valid, input finished,
                  input error_code, output ready);
endinterface

interface cwp_cfg_if;
  logic           valid;
  logic           ready;
  cwp_pkg::deg_t  degree_limit;

  modport source (output valid, output degree_limit, input ready);
  modport sink   (input valid, input degree_limit, output ready);
endinterface

`default_nettype wire

### hdl/certificate_text_to_word_parser.sv
// Top level of the certificate text-to-word parser.
// Depends on cwp_pkg and the channel interfaces in cwp_ifs.sv.
//
//   channel  direction  payload                                         transaction
//   in_ch    in         text_byte[7:0], end_of_input                     valid & ready
//   out_ch   out        packed_word[63:0], word_valid, finished,         valid & ready
//                       error_code[2:0]
//   cfg_ch   in         degree_limit[5:0]                                valid & ready
//
// One byte per cycle while the output is not stalled: a byte is registered in the input
// register, parsed from there, and a result, if any, is written into the output register.
// The parse cycle is set by the 64-bit multiply-by-ten add and line-number compare.
// The input register moves on whenever the output register is empty or being taken.
// Reset is synchronous and active low; cfg_ch is always ready.
`default_nettype none

module certificate_text_to_word_parser (
  input  wire logic     clk,
  input  wire logic     rst_n,
  cwp_in_if.sink        in_ch,
  cwp_out_if.source     out_ch,
  cwp_cfg_if.sink       cfg_ch
);

  typedef enum logic [2:0] {
    PH_WS   = 3'd0,
    PH_NUM  = 3'd1,
    PH_GAP  = 3'd2,
    PH_DEG  = 3'd3,
    PH_PREP = 3'd4,
    PH_HEX  = 3'd5,
    PH_SKIP = 3'd6,
    PH_DONE = 3'd7
  } phase_t;

  phase_t          phase_r, phase_nxt;
  cwp_pkg::word_t  exp_r, exp_nxt;
  cwp_pkg::word_t  dec_r, dec_nxt;
  cwp_pkg::deg_t   deg_r, deg_nxt;
  cwp_pkg::word_t  hex_r, hex_nxt;
  cwp_pkg::deg_t   limit_r;

  logic            s1_valid_r;
  cwp_pkg::byte_t  s1_byte_r;
  logic            s1_eof_r;
  logic            s1_fire;

  logic            out_valid_r;
  cwp_pkg::word_t  out_word_r;
  logic            out_wv_r;
  logic            out_fin_r;
  cwp_pkg::err_t   out_err_r;

  logic            res_fire;
  cwp_pkg::word_t  res_word;
  logic            res_wv;
  logic            res_fin;
  cwp_pkg::err_t   res_err;

  logic            eof, blank, digit, is_lf, is_cr, is_sp;
  logic [3:0]      dv;
  logic [4:0]      hd;
  cwp_pkg::word_t  mul10;
  cwp_pkg::word_t  upper_mask;
  logic            size_ok;
  logic            gap_go, prep_go;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packed_word = out_word_r;
  assign out_ch.word_valid  = out_wv_r;
  assign out_ch.finished    = out_fin_r;
  assign out_ch.error_code  = out_err_r;

  assign eof   = s1_eof_r;
  assign is_sp = !eof && s1_byte_r == cwp_pkg::ChSpace;
  assign is_lf = !eof && s1_byte_r == cwp_pkg::ChLf;
  assign is_cr = !eof && s1_byte_r == cwp_pkg::ChCr;
  assign blank = is_sp || (!eof && s1_byte_r == cwp_pkg::ChTab);
  assign digit = !eof && s1_byte_r >= cwp_pkg::ChZero && s1_byte_r <= cwp_pkg::ChNine;
  assign dv    = digit ? 4'(s1_byte_r - cwp_pkg::ChZero) : 4'd0;
  assign hd    = eof ? 5'd0 : cwp_pkg::hex_digit(s1_byte_r);
  assign mul10 = (dec_r << 3) + (dec_r << 1) + cwp_pkg::WordW'(dv);

  // The payload is well sized when bit d is set and nothing above it is.
  assign upper_mask = (cwp_pkg::AllOnes << deg_r) << 1;
  assign size_ok    = hex_r[deg_r] && ((hex_r & upper_mask) == '0);

  always_comb begin
    phase_nxt = phase_r;
    exp_nxt   = exp_r;
    dec_nxt   = dec_r;
    deg_nxt   = deg_r;
    hex_nxt   = hex_r;
    res_fire  = 1'b0;
    res_word  = '0;
    res_wv    = 1'b0;
    res_fin   = 1'b0;
    res_err   = cwp_pkg::ERR_NONE;
    gap_go    = 1'b0;
    prep_go   = 1'b0;
    if (s1_fire) begin
      unique case (phase_r)
        PH_WS: begin
          if (eof) begin
            phase_nxt = PH_DONE;
            res_fire  = 1'b1;
            res_fin   = 1'b1;
          end else if (blank || is_lf || is_cr) begin
            phase_nxt = PH_WS;
          end else if (digit) begin
            dec_nxt   = cwp_pkg::WordW'(dv);
            phase_nxt = PH_NUM;
          end else begin
            phase_nxt = PH_DONE;
            res_fire  = 1'b1;
            res_fin   = 1'b1;
            res_err   = cwp_pkg::ERR_NO_LINE;
          end
        end
        PH_NUM: begin
          if (digit) begin
            dec_nxt = mul10;
          end else if (dec_r != exp_r) begin
            phase_nxt = PH_DONE;
            res_fire  = 1'b1;
            res_fin   = 1'b1;
            res_err   = cwp_pkg::ERR_LINE_MISM;
          end else begin
            gap_go = 1'b1;
          end
        end
        PH_GAP:  gap_go = 1'b1;
        PH_DEG: begin
          if (digit) begin
            dec_nxt = mul10;
          end else begin
            prep_go = 1'b1;
          end
        end
        PH_PREP: prep_go = 1'b1;
        PH_HEX: begin
          if (eof || is_lf || is_cr || is_sp) begin
            if (!size_ok) begin
              phase_nxt = PH_DONE;
              res_fire  = 1'b1;
              res_fin   = 1'b1;
              res_err   = cwp_pkg::ERR_SIZE_MISM;
            end else begin
              exp_nxt   = exp_r + cwp_pkg::WordW'(1);
              phase_nxt = eof ? PH_DONE : PH_WS;
              res_fire  = 1'b1;
              res_wv    = 1'b1;
              res_fin   = eof;
              res_word  = (cwp_pkg::WordW'(deg_r) << cwp_pkg::DegShift) | hex_r;
            end
          end else if (!hd[4]) begin
            phase_nxt = PH_DONE;
            res_fire  = 1'b1;
            res_fin   = 1'b1;
            res_err   = cwp_pkg::ERR_BAD_HEX;
          end else begin
            hex_nxt = {hex_r[cwp_pkg::WordW-5:0], hd[3:0]};
          end
        end
        PH_SKIP: begin
          if (eof) begin
            phase_nxt = PH_DONE;
            res_fire  = 1'b1;
            res_fin   = 1'b1;
          end else if (is_lf) begin
            phase_nxt = PH_WS;
          end
        end
        PH_DONE: phase_nxt = PH_DONE;
        default: phase_nxt = PH_DONE;
      endcase

      if (gap_go) begin
        if (blank) begin
          phase_nxt = PH_GAP;
        end else if (!eof && s1_byte_r == cwp_pkg::ChU) begin
          exp_nxt   = exp_r + cwp_pkg::WordW'(1);
          phase_nxt = PH_SKIP;
          res_fire  = 1'b1;
          res_wv    = 1'b1;
          res_word  = cwp_pkg::AllOnes;
        end else if (digit) begin
          dec_nxt   = cwp_pkg::WordW'(dv);
          phase_nxt = PH_DEG;
        end else begin
          phase_nxt = PH_DONE;
          res_fire  = 1'b1;
          res_fin   = 1'b1;
          res_err   = cwp_pkg::ERR_NOT_U_DIG;
        end
      end

      if (prep_go) begin
        if (blank) begin
          phase_nxt = PH_PREP;
        end else if (eof || s1_byte_r != cwp_pkg::ChP) begin
          phase_nxt = PH_DONE;
          res_fire  = 1'b1;
          res_fin   = 1'b1;
          res_err   = cwp_pkg::ERR_NO_P;
        end else if (dec_r > cwp_pkg::WordW'(limit_r)) begin
          exp_nxt   = exp_r + cwp_pkg::WordW'(1);
          phase_nxt = PH_SKIP;
          res_fire  = 1'b1;
          res_wv    = 1'b1;
          res_word  = cwp_pkg::AllOnes;
        end else begin
          deg_nxt   = dec_r[cwp_pkg::DegW-1:0];
          hex_nxt   = '0;
          phase_nxt = PH_HEX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WS;
      exp_r       <= cwp_pkg::WordW'(1);
      dec_r       <= '0;
      deg_r       <= '0;
      hex_r       <= '0;
      limit_r     <= cwp_pkg::DegLimitReset;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      exp_r   <= exp_nxt;
      dec_r   <= dec_nxt;
      deg_r   <= deg_nxt;
      hex_r   <= hex_nxt;
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.degree_limit;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (in_ch.valid && in_ch.ready) begin
        s1_byte_r <= in_ch.text_byte;
        s1_eof_r  <= in_ch.end_of_input;
      end
      if (s1_fire && res_fire) begin
        out_valid_r <= 1'b1;
        out_word_r  <= res_word;
        out_wv_r    <= res_wv;
        out_fin_r   <= res_fin;
        out_err_r   <= res_err;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
